// ----- hdl/sccfc_pkg.sv -----
// Shared types and constants for the sum checksum frame checker.
package sccfc_pkg;

    localparam int POS_W = 9;

    typedef logic [POS_W-1:0] t_pos;

    localparam t_pos POS_COMMAND = t_pos'(3);
    localparam t_pos POS_LENGTH  = t_pos'(4);
    localparam t_pos POS_PAYLOAD = t_pos'(5);

    localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd64;

    // Header bytes as sent by a well formed transmitter; not checked on receive.
    localparam logic [15:0] HEADER_MAGIC = 16'hAB57;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_LEN_ERR = 2'd1,
        ST_SUM_ERR = 2'd2
    } t_status;

    typedef enum logic {
        KIND_PAYLOAD   = 1'b0,
        KIND_FRAME_END = 1'b1
    } t_kind;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_rx_payload;

    typedef struct packed {
        t_kind      out_kind;
        logic [7:0] payload_byte;
        logic [7:0] frame_command;
        logic [7:0] payload_length;
        t_status    status;
        logic       last;
    } t_res_payload;

    // Registered receive request handed from the input stage to the frame stage.
    typedef struct packed {
        logic        valid;
        t_rx_payload data;
    } t_rx_stage;

endpackage

// ----- hdl/sccfc_stream_if.sv -----
// Valid/ready stream channel carrying one payload word per request.
interface sccfc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/sccfc_in_reg.sv -----
// Input register stage for received byte requests.
module sccfc_in_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sccfc_stream_if.sink         i_rx,
    input  logic                 i_advance,
    output sccfc_pkg::t_rx_stage o_stage
);

    logic                   r_valid;
    sccfc_pkg::t_rx_payload r_data;

    // Take a new request whenever the held one is empty or moves on this cycle.
    assign i_rx.ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_data <= i_rx.payload;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.data  = r_data;

endmodule

// ----- hdl/sccfc_frame.sv -----
// Frame position tracking, running sum, length and checksum checks, result register.
module sccfc_frame (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sccfc_pkg::t_rx_stage i_stage,
    input  logic [7:0]           i_max_payload,
    output logic                 o_advance,
    sccfc_stream_if.source       o_res
);

    sccfc_pkg::t_pos r_pos, n_pos;
    logic [7:0]      r_sum, n_sum;
    logic [7:0]      r_len, n_len;
    logic [7:0]      r_cmd, n_cmd;
    logic            r_in_frame, n_in_frame;

    logic                    r_out_valid;
    sccfc_pkg::t_res_payload r_out;

    logic                    res_valid;
    sccfc_pkg::t_res_payload res;
    logic                    consume;
    logic                    start;
    logic                    eff_in_frame;
    sccfc_pkg::t_pos         pos;
    sccfc_pkg::t_pos         check_pos;
    logic [7:0]              sum;
    logic [7:0]              len;
    logic [7:0]              cmd;
    logic [7:0]              b;

    assign o_advance = !r_out_valid || o_res.ready;
    assign consume   = o_advance && i_stage.valid;

    assign b            = i_stage.data.rx_byte;
    assign start        = i_stage.data.frame_start;
    assign eff_in_frame = start || r_in_frame;
    // A frame start drops whatever frame was running and begins fresh.
    assign pos          = start ? '0 : r_pos;
    assign sum          = start ? '0 : r_sum;
    assign len          = start ? '0 : r_len;
    assign cmd          = start ? '0 : r_cmd;
    assign check_pos    = sccfc_pkg::POS_PAYLOAD + sccfc_pkg::t_pos'(len);

    always_comb begin
        n_pos      = r_pos;
        n_sum      = r_sum;
        n_len      = r_len;
        n_cmd      = r_cmd;
        n_in_frame = r_in_frame;
        res_valid  = 1'b0;
        res.out_kind       = sccfc_pkg::KIND_PAYLOAD;
        res.payload_byte   = 8'd0;
        res.frame_command  = cmd;
        res.payload_length = len;
        res.status         = sccfc_pkg::ST_OK;
        res.last           = 1'b0;

        if (consume && eff_in_frame) begin
            n_in_frame = 1'b1;
            n_pos      = pos;
            n_sum      = sum;
            n_len      = len;
            n_cmd      = cmd;
            if (pos < sccfc_pkg::POS_LENGTH) begin
                if (pos == sccfc_pkg::POS_COMMAND) begin
                    n_cmd = b;
                    res.frame_command = b;
                end
                n_sum = sum + b;
                n_pos = pos + 1'b1;
            end else if (pos == sccfc_pkg::POS_LENGTH) begin
                n_len = b;
                n_sum = sum + b;
                n_pos = pos + 1'b1;
                res.payload_length = b;
                if (b > i_max_payload) begin
                    // Length above the limit: end the frame now.
                    n_in_frame = 1'b0;
                    res_valid  = 1'b1;
                    res.out_kind = sccfc_pkg::KIND_FRAME_END;
                    res.status   = sccfc_pkg::ST_LEN_ERR;
                    res.last     = 1'b1;
                end
            end else if (pos < check_pos) begin
                n_sum = sum + b;
                n_pos = pos + 1'b1;
                res_valid = 1'b1;
                res.payload_byte = b;
            end else begin
                // Checksum byte closes the frame.
                n_in_frame = 1'b0;
                res_valid  = 1'b1;
                res.out_kind = sccfc_pkg::KIND_FRAME_END;
                res.status   = (b == sum) ? sccfc_pkg::ST_OK : sccfc_pkg::ST_SUM_ERR;
                res.last     = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_sum       <= '0;
            r_len       <= '0;
            r_cmd       <= '0;
            r_in_frame  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_sum      <= n_sum;
            r_len      <= n_len;
            r_cmd      <= n_cmd;
            r_in_frame <= n_in_frame;
            if (o_advance) begin
                r_out_valid <= res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

endmodule

// ----- hdl/sum_checksum_frame_checker.sv -----
// Top level of the sum checksum frame checker.
// Receive-side checker for byte frames: two header bytes, address, command,
// length, payload and an 8-bit sum checksum over every earlier byte. It takes
// one byte request per cycle and returns each result from the result register:
// each payload byte is passed on, and the checksum byte or an over-limit length
// gives one frame-end result with status. Header, address and command bytes give
// no result. A request with frame_start set always begins a new frame and drops
// any frame in progress silently; other bytes outside a frame are ignored. The
// throughput of one byte per cycle is set by the combinational position update
// and 8-bit add of the frame stage; input ready follows output ready through the
// input register. Write max_payload (reset 64) only while no bytes are in flight.
module sum_checksum_frame_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sccfc_stream_if.sink   i_rx,
    sccfc_stream_if.source o_res,
    input  logic           i_cfg_we,
    input  logic [7:0]     i_cfg_data
);

    logic [7:0]           r_max_len;
    sccfc_pkg::t_rx_stage stage;
    logic                 advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= sccfc_pkg::MAX_PAYLOAD_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_data;
        end
    end

    sccfc_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .i_advance (advance),
        .o_stage   (stage)
    );

    sccfc_frame u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_stage       (stage),
        .i_max_payload (r_max_len),
        .o_advance     (advance),
        .o_res         (o_res)
    );

endmodule

// ----- tb/tb.sv -----
// Testbench for the sum checksum frame checker: directed frame table, then random frames.
module tb;
    import sccfc_pkg::*;

    localparam int N_DIR      = 23;
    localparam int N_PHASES   = 6;
    localparam int PHASE_REQS = 320;
    localparam int HOLD_PHASE = 5;
    localparam int HOLD_LEN   = 120;
    localparam int LIMIT      = 400_000;

    typedef enum logic [1:0] {
        CHK_NONE,
        CHK_PRED,
        CHK_GIVEN
    } t_chk;

    typedef struct packed {
        logic [7:0]   rx_byte;
        logic         frame_start;
        t_chk         chk;
        t_res_payload res;
    } t_dir_row;

    // Hand-checked frames: good frame, over-limit length, restart inside a frame, bad sum.
    localparam t_dir_row DIR_TAB [N_DIR] = '{
        '{8'h12, 1'b0, CHK_NONE, '0},
        '{8'h57, 1'b1, CHK_NONE, '0},
        '{8'hAB, 1'b0, CHK_NONE, '0},
        '{8'h01, 1'b0, CHK_NONE, '0},
        '{8'h80, 1'b0, CHK_NONE, '0},
        '{8'h02, 1'b0, CHK_NONE, '0},
        '{8'hFF, 1'b0, CHK_GIVEN, '{KIND_PAYLOAD, 8'hFF, 8'h80, 8'h02, ST_OK, 1'b0}},
        '{8'h00, 1'b0, CHK_GIVEN, '{KIND_PAYLOAD, 8'h00, 8'h80, 8'h02, ST_OK, 1'b0}},
        '{8'h84, 1'b0, CHK_GIVEN, '{KIND_FRAME_END, 8'h00, 8'h80, 8'h02, ST_OK, 1'b1}},
        '{8'h57, 1'b1, CHK_PRED, '0},
        '{8'hAB, 1'b0, CHK_PRED, '0},
        '{8'h00, 1'b0, CHK_PRED, '0},
        '{8'hFF, 1'b0, CHK_PRED, '0},
        '{8'h41, 1'b0, CHK_GIVEN, '{KIND_FRAME_END, 8'h00, 8'hFF, 8'h41, ST_LEN_ERR, 1'b1}},
        '{8'h33, 1'b0, CHK_NONE, '0},
        '{8'hFF, 1'b1, CHK_PRED, '0},
        '{8'hFF, 1'b0, CHK_PRED, '0},
        '{8'h57, 1'b1, CHK_PRED, '0},
        '{8'hAB, 1'b0, CHK_PRED, '0},
        '{8'h00, 1'b0, CHK_PRED, '0},
        '{8'h05, 1'b0, CHK_PRED, '0},
        '{8'h00, 1'b0, CHK_PRED, '0},
        '{8'h7E, 1'b0, CHK_GIVEN, '{KIND_FRAME_END, 8'h00, 8'h05, 8'h00, ST_SUM_ERR, 1'b1}}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_data;

    sccfc_stream_if #(.T(t_rx_payload))  rx_ch ();
    sccfc_stream_if #(.T(t_res_payload)) res_ch ();

    sum_checksum_frame_checker u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (rx_ch.sink),
        .o_res      (res_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // Predictor state
    t_pos       frame_pos;
    logic [7:0] frame_sum;
    logic [7:0] frame_len;
    logic [7:0] frame_cmd;
    logic       frame_open;
    logic [7:0] max_len_cfg;

    t_res_payload pending_res [$];

    int n_errors      = 0;
    int n_taken       = 0;
    int cycles        = 0;
    int phase_no      = 0;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, pending_res.size());
            $display("Verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("cycle %0d: %s", cycles, what);
        n_errors++;
    endtask

    function automatic bit predict_frame_byte(input t_rx_payload req, output t_res_payload res);
        t_pos pos;
        t_pos end_pos;
        res = '0;
        if (req.frame_start) begin
            frame_open = 1'b1;
            frame_pos  = '0;
            frame_sum  = '0;
            frame_len  = '0;
            frame_cmd  = '0;
        end
        if (!frame_open)
            return 1'b0;
        n_taken++;
        pos     = frame_pos;
        end_pos = POS_PAYLOAD + t_pos'(frame_len);
        if (pos < POS_LENGTH) begin
            if (pos == POS_COMMAND)
                frame_cmd = req.rx_byte;
            frame_sum = frame_sum + req.rx_byte;
            frame_pos = pos + 1'b1;
            return 1'b0;
        end
        if (pos == POS_LENGTH) begin
            frame_len = req.rx_byte;
            frame_sum = frame_sum + req.rx_byte;
            frame_pos = pos + 1'b1;
            if (req.rx_byte <= max_len_cfg)
                return 1'b0;
            frame_open         = 1'b0;
            res.out_kind       = KIND_FRAME_END;
            res.frame_command  = frame_cmd;
            res.payload_length = frame_len;
            res.status         = ST_LEN_ERR;
            res.last           = 1'b1;
            return 1'b1;
        end
        res.frame_command  = frame_cmd;
        res.payload_length = frame_len;
        if (pos < end_pos) begin
            frame_sum        = frame_sum + req.rx_byte;
            frame_pos        = pos + 1'b1;
            res.out_kind     = KIND_PAYLOAD;
            res.payload_byte = req.rx_byte;
            return 1'b1;
        end
        // checksum byte closes the frame
        frame_open   = 1'b0;
        res.out_kind = KIND_FRAME_END;
        res.status   = (req.rx_byte == frame_sum) ? ST_OK : ST_SUM_ERR;
        res.last     = 1'b1;
        return 1'b1;
    endfunction

    task automatic send_req(input logic [7:0] b, input logic sof, input t_chk chk,
                            input t_res_payload given);
        t_rx_payload  req;
        t_res_payload res;
        bit           has_res;
        req.rx_byte     = b;
        req.frame_start = sof;
        while ($urandom_range(99) < src_idle_pct) begin
            rx_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.payload <= req;
        do
            @(posedge i_clk);
        while (!rx_ch.ready);
        has_res = predict_frame_byte(req, res);
        if (chk == CHK_PRED && has_res)
            pending_res.push_back(res);
        else if (chk == CHK_GIVEN)
            pending_res.push_back(given);
    endtask

    task automatic send_frame();
        logic [7:0] fb;
        logic [7:0] sum;
        int         kind;
        int         len;
        int         cut;
        int         r;
        kind = $urandom_range(99);
        if (kind < 8) begin
            // noise: loose bytes, now and then a stray frame start
            repeat ($urandom_range(1, 4))
                send_req(8'($urandom), $urandom_range(15) == 0, CHK_PRED, '0);
            return;
        end
        r = $urandom_range(99);
        if (kind < 18 && max_len_cfg != 8'hFF)
            len = $urandom_range(255, int'(max_len_cfg) + 1);
        else if (r < 3)
            len = int'(max_len_cfg);
        else if (r < 10)
            len = $urandom_range(int'(max_len_cfg), 0);
        else
            len = $urandom_range((max_len_cfg < 8) ? int'(max_len_cfg) : 8, 0);
        cut = (kind < 28) ? int'($urandom_range(5 + len, 1)) : -1;
        sum = '0;
        for (int idx = 0; idx < 6 + len; idx++) begin
            // drop the rest of a truncated frame; the next frame start restarts it
            if (idx == cut)
                return;
            if (idx == 0)
                fb = ($urandom_range(9) == 0) ? 8'($urandom) : HEADER_MAGIC[7:0];
            else if (idx == 1)
                fb = ($urandom_range(9) == 0) ? 8'($urandom) : HEADER_MAGIC[15:8];
            else if (idx == int'(POS_LENGTH))
                fb = 8'(len);
            else if (idx == 5 + len && $urandom_range(9) != 0)
                fb = sum;
            else
                fb = 8'($urandom);
            send_req(fb, idx == 0, CHK_PRED, '0);
            sum = sum + fb;
            if (idx == int'(POS_LENGTH) && len > int'(max_len_cfg))
                return;
        end
    endtask

    task automatic wait_drained();
        rx_ch.valid <= 1'b0;
        while (pending_res.size() != 0)
            @(posedge i_clk);
        // header bytes give no result and may still be in the pipe
        repeat (4) @(posedge i_clk);
    endtask

    // Result side: random backpressure plus one long hold-off to fill the block.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            res_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (phase_no == HOLD_PHASE && !hold_done) begin
            res_ch.ready <= 1'b0;
            hold_left    <= HOLD_LEN;
            hold_done    <= 1'b1;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_res_payload want;
        t_res_payload got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = res_ch.payload;
            if (pending_res.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
            end else begin
                want = pending_res.pop_front();
                if (got.out_kind !== want.out_kind)
                    report_mismatch($sformatf("out_kind %h, want %h", got.out_kind, want.out_kind));
                if (got.payload_byte !== want.payload_byte)
                    report_mismatch($sformatf("payload_byte %h, want %h",
                                              got.payload_byte, want.payload_byte));
                if (got.frame_command !== want.frame_command)
                    report_mismatch($sformatf("frame_command %h, want %h",
                                              got.frame_command, want.frame_command));
                if (got.payload_length !== want.payload_length)
                    report_mismatch($sformatf("payload_length %h, want %h",
                                              got.payload_length, want.payload_length));
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %h, want %h", got.status, want.status));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last %h, want %h", got.last, want.last));
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_data    <= '0;
        rx_ch.valid   <= 1'b0;
        rx_ch.payload <= '0;
        frame_pos     = '0;
        frame_sum     = '0;
        frame_len     = '0;
        frame_cmd     = '0;
        frame_open    = 1'b0;
        max_len_cfg   = MAX_PAYLOAD_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct  = 18;
        sink_idle_pct = 73;
        for (int i = 0; i < N_DIR; i++)
            send_req(DIR_TAB[i].rx_byte, DIR_TAB[i].frame_start, DIR_TAB[i].chk, DIR_TAB[i].res);
        wait_drained();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            logic [7:0] lim;
            case (ph)
                0:       lim = 8'd0;
                1:       lim = 8'd255;
                2:       lim = 8'd8;
                4:       lim = MAX_PAYLOAD_RESET;
                default: lim = 8'($urandom_range(254, 1));
            endcase
            src_idle_pct  = (ph < 2) ? 18 : (ph < 4) ? 73 : 0;
            sink_idle_pct = (ph < 2) ? 73 : (ph < 4) ? 18 : 0;
            i_cfg_we   <= 1'b1;
            i_cfg_data <= lim;
            @(posedge i_clk);
            i_cfg_we    <= 1'b0;
            max_len_cfg = lim;
            phase_no    = ph + 1;
            n_taken     = 0;
            while (n_taken < PHASE_REQS)
                send_frame();
            wait_drained();
        end

        repeat (6) @(posedge i_clk);
        if (n_errors == 0 && pending_res.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
